@@ rtl/dyfd_pkg.sv @@
`timescale 1ns / 1ps

package dyfd_pkg;

    localparam int MAX_GROUPS_PER_LINE = 1024;
    localparam int MAX_LINES           = 4096;

    localparam int HDR_SKIP     = 16;
    localparam int HDR_LUMA_END = 32;
    localparam int HDR_LEN      = 16 * 3;

    localparam int BYTE_W  = 8;
    localparam int NIB_W   = 4;
    localparam int GPL_W   = 11;
    localparam int LPF_W   = 13;
    localparam int HDR_W   = 6;
    localparam int GRP_W   = 10;
    localparam int LINE_W  = 12;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GROUPS_PER_LINE = 1'b0,
        REG_LINES_PER_FRAME = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_P0   = 2'd1,
        K_P1   = 2'd2,
        K_P2   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  first;
        logic  line_end;
        logic  frame_end;
    } t_s1_ctl;

endpackage

@@ rtl/dpcm_yuv411_frame_decoder.sv @@
`timescale 1ns / 1ps

// dpcm yuv 4:1:1 frame decoder, coded bytes in, yuy2 pixel pairs out
// input channel: i_valid / o_stall, one coded byte per item, i_frame_start
//   on the first byte of a frame; bytes outside a frame are dropped
// output channel: o_valid / i_stall, one pixel pair per item, with
//   o_line_end and o_frame_end flags on the last pair of a line / frame
// config channel: i_cfg_valid / o_cfg_ready (always ready), index 0 is
//   groups per line, index 1 is lines per frame; write only while idle
// output path: a taken byte and its delta table reads are registered in
//   stage one, then the add stage loads the output register
// throughput: one byte per cycle when not stalled, set by the two-stage
//   pipeline that moves as a whole; bytes two and three of a group give a pair
// stall: when a pair waits under i_stall the whole pipeline holds and
//   o_stall goes high, so no item is lost or repeated
// reset: counters clear, no frame is active, geometry returns to 80 groups
//   by 240 lines; the delta tables are loaded by every frame header
module dpcm_yuv411_frame_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [dyfd_pkg::BYTE_W-1:0]   i_code_byte,
    input  logic                          i_frame_start,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [dyfd_pkg::BYTE_W-1:0]   o_luma_first,
    output logic [dyfd_pkg::BYTE_W-1:0]   o_chroma_u,
    output logic [dyfd_pkg::BYTE_W-1:0]   o_luma_second,
    output logic [dyfd_pkg::BYTE_W-1:0]   o_chroma_v,
    output logic                          o_line_end,
    output logic                          o_frame_end,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dyfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dyfd_pkg::CFG_W-1:0]    i_cfg_data
);
    import dyfd_pkg::*;

    logic [GPL_W-1:0]  r_groups_per_line;
    logic [LPF_W-1:0]  r_lines_per_frame;

    logic              r_frame_active, n_frame_active;
    logic [HDR_W-1:0]  r_header_count, n_header_count;
    t_phase            r_byte_phase, n_byte_phase;
    logic [GRP_W-1:0]  r_group_count, n_group_count;
    logic [LINE_W-1:0] r_line_count, n_line_count;

    logic [BYTE_W-1:0] r_luma_mem   [16];
    logic [BYTE_W-1:0] r_chroma_mem [16];

    t_s1_ctl           r_s1_ctl, n_s1_ctl;
    logic [BYTE_W-1:0] r_s1_byte;
    logic [BYTE_W-1:0] r_s1_luma_lo;
    logic [BYTE_W-1:0] r_s1_luma_hi;
    logic [BYTE_W-1:0] r_s1_chroma_hi;

    logic [BYTE_W-1:0] r_running_luma, n_running_luma;
    logic [BYTE_W-1:0] r_running_u, n_running_u;
    logic [BYTE_W-1:0] r_running_v, n_running_v;
    logic [BYTE_W-1:0] r_held_luma, n_held_luma;

    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_y0, n_out_y0;
    logic [BYTE_W-1:0] r_out_u, n_out_u;
    logic [BYTE_W-1:0] r_out_y1, n_out_y1;
    logic [BYTE_W-1:0] r_out_v, n_out_v;
    logic              r_out_le, n_out_le;
    logic              r_out_fe, n_out_fe;

    logic              advance;
    logic              accept;
    logic              luma_we, chroma_we;
    logic [NIB_W-1:0]  nib_lo, nib_hi;
    logic [GPL_W-1:0]  gpl;
    logic [LPF_W-1:0]  lpf;
    logic              active;
    logic [HDR_W-1:0]  hc;
    t_phase            ph;
    logic [GRP_W-1:0]  gc;
    logic [LINE_W-1:0] lc;
    logic [BYTE_W-1:0] y_mid;

    assign advance     = !r_out_valid || !i_stall;
    assign accept      = i_valid && advance;
    assign o_stall     = !advance;
    assign o_cfg_ready = 1'b1;
    assign nib_lo      = i_code_byte[NIB_W-1:0];
    assign nib_hi      = i_code_byte[BYTE_W-1:NIB_W];

    // clamp geometry to the supported range
    always_comb begin
        if (r_groups_per_line == '0) begin
            gpl = GPL_W'(1);
        end else if (r_groups_per_line > GPL_W'(MAX_GROUPS_PER_LINE)) begin
            gpl = GPL_W'(MAX_GROUPS_PER_LINE);
        end else begin
            gpl = r_groups_per_line;
        end
        if (r_lines_per_frame == '0) begin
            lpf = LPF_W'(1);
        end else if (r_lines_per_frame > LPF_W'(MAX_LINES)) begin
            lpf = LPF_W'(MAX_LINES);
        end else begin
            lpf = r_lines_per_frame;
        end
    end

    // stage one: frame position tracking and header table loads
    always_comb begin
        active = i_frame_start || r_frame_active;
        hc     = i_frame_start ? '0 : r_header_count;
        ph     = i_frame_start ? PH_FIRST : r_byte_phase;
        gc     = i_frame_start ? '0 : r_group_count;
        lc     = i_frame_start ? '0 : r_line_count;

        n_frame_active = r_frame_active;
        n_header_count = r_header_count;
        n_byte_phase   = r_byte_phase;
        n_group_count  = r_group_count;
        n_line_count   = r_line_count;
        n_s1_ctl       = '{kind: K_NONE, first: 1'b0, line_end: 1'b0, frame_end: 1'b0};
        luma_we        = 1'b0;
        chroma_we      = 1'b0;

        if (accept && active) begin
            n_frame_active = 1'b1;
            n_header_count = hc;
            n_byte_phase   = ph;
            n_group_count  = gc;
            n_line_count   = lc;
            if (hc < HDR_W'(HDR_LEN)) begin
                if (hc >= HDR_W'(HDR_LUMA_END)) begin
                    chroma_we = 1'b1;
                end else if (hc >= HDR_W'(HDR_SKIP)) begin
                    luma_we = 1'b1;
                end
                n_header_count = hc + HDR_W'(1);
            end else begin
                n_s1_ctl.first = (gc == '0);
                case (ph)
                    PH_FIRST: begin
                        n_s1_ctl.kind = K_P0;
                        n_byte_phase  = PH_SECOND;
                    end
                    PH_SECOND: begin
                        n_s1_ctl.kind = K_P1;
                        n_byte_phase  = PH_THIRD;
                    end
                    default: begin
                        n_s1_ctl.kind = K_P2;
                        n_byte_phase  = PH_FIRST;
                        if (({1'b0, gc} + GPL_W'(1)) >= gpl) begin
                            n_group_count     = '0;
                            n_s1_ctl.line_end = 1'b1;
                            if (({1'b0, lc} + LPF_W'(1)) >= lpf) begin
                                n_s1_ctl.frame_end = 1'b1;
                                n_line_count       = '0;
                                n_frame_active     = 1'b0;
                            end else begin
                                n_line_count = lc + LINE_W'(1);
                            end
                        end else begin
                            n_group_count = gc + GRP_W'(1);
                        end
                    end
                endcase
            end
        end
    end

    // stage two: running sample update and pair formation
    always_comb begin
        n_running_luma = r_running_luma;
        n_running_u    = r_running_u;
        n_running_v    = r_running_v;
        n_held_luma    = r_held_luma;
        n_out_valid    = 1'b0;
        n_out_y0       = r_out_y0;
        n_out_u        = r_out_u;
        n_out_y1       = r_out_y1;
        n_out_v        = r_out_v;
        n_out_le       = 1'b0;
        n_out_fe       = 1'b0;
        y_mid          = r_running_luma + r_s1_luma_lo;

        case (r_s1_ctl.kind)
            K_P0: begin
                if (r_s1_ctl.first) begin
                    n_running_u    = {r_s1_byte[BYTE_W-1:NIB_W], NIB_W'(0)};
                    n_running_luma = {r_s1_byte[NIB_W-1:0], NIB_W'(0)};
                end else begin
                    n_running_u    = r_running_u + r_s1_chroma_hi;
                    n_running_luma = y_mid;
                end
                n_held_luma = n_running_luma;
            end
            K_P1: begin
                if (r_s1_ctl.first) begin
                    n_running_v = {r_s1_byte[BYTE_W-1:NIB_W], NIB_W'(0)};
                end else begin
                    n_running_v = r_running_v + r_s1_chroma_hi;
                end
                n_running_luma = y_mid;
                n_out_valid    = 1'b1;
                n_out_y0       = r_held_luma;
                n_out_u        = r_running_u;
                n_out_y1       = y_mid;
                n_out_v        = n_running_v;
            end
            K_P2: begin
                n_running_luma = y_mid + r_s1_luma_hi;
                n_out_valid    = 1'b1;
                n_out_y0       = y_mid;
                n_out_u        = r_running_u;
                n_out_y1       = n_running_luma;
                n_out_v        = r_running_v;
                n_out_le       = r_s1_ctl.line_end;
                n_out_fe       = r_s1_ctl.frame_end;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_groups_per_line <= GPL_W'(80);
            r_lines_per_frame <= LPF_W'(240);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_GROUPS_PER_LINE: r_groups_per_line <= i_cfg_data[GPL_W-1:0];
                REG_LINES_PER_FRAME: r_lines_per_frame <= i_cfg_data[LPF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_active <= 1'b0;
            r_header_count <= '0;
            r_byte_phase   <= PH_FIRST;
            r_group_count  <= '0;
            r_line_count   <= '0;
            r_s1_ctl       <= '{kind: K_NONE, first: 1'b0, line_end: 1'b0, frame_end: 1'b0};
            r_out_valid    <= 1'b0;
            r_out_le       <= 1'b0;
            r_out_fe       <= 1'b0;
        end else if (advance) begin
            r_frame_active <= n_frame_active;
            r_header_count <= n_header_count;
            r_byte_phase   <= n_byte_phase;
            r_group_count  <= n_group_count;
            r_line_count   <= n_line_count;
            r_s1_ctl       <= n_s1_ctl;
            r_out_valid    <= n_out_valid;
            r_out_le       <= n_out_le;
            r_out_fe       <= n_out_fe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_luma <= '0;
            r_running_u    <= '0;
            r_running_v    <= '0;
            r_held_luma    <= '0;
        end else if (advance) begin
            r_running_luma <= n_running_luma;
            r_running_u    <= n_running_u;
            r_running_v    <= n_running_v;
            r_held_luma    <= n_held_luma;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_byte <= i_code_byte;
            r_out_y0  <= n_out_y0;
            r_out_u   <= n_out_u;
            r_out_y1  <= n_out_y1;
            r_out_v   <= n_out_v;
        end
    end

    // delta tables, one write port each, registered reads
    always_ff @(posedge i_clk) begin
        if (luma_we) begin
            r_luma_mem[hc[NIB_W-1:0]] <= i_code_byte;
        end
        if (chroma_we) begin
            r_chroma_mem[hc[NIB_W-1:0]] <= i_code_byte;
        end
        if (advance) begin
            r_s1_luma_lo   <= r_luma_mem[nib_lo];
            r_s1_luma_hi   <= r_luma_mem[nib_hi];
            r_s1_chroma_hi <= r_chroma_mem[nib_hi];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_luma_first  = r_out_y0;
    assign o_chroma_u    = r_out_u;
    assign o_luma_second = r_out_y1;
    assign o_chroma_v    = r_out_v;
    assign o_line_end    = r_out_le;
    assign o_frame_end   = r_out_fe;

endmodule
